>>> design/usbief_pkg.sv
// ----------------------------------------------------------------------------
// usbief_pkg
// Shared types, constants and helpers for the interrupt IN endpoint finder.
// ----------------------------------------------------------------------------
package usbief_pkg;

  // Descriptor field codes
  localparam logic [7:0] DescTypeEndpoint = 8'h05;
  localparam logic [7:0] EpDirInMask      = 8'h80;
  localparam logic [7:0] EpXferTypeMask   = 8'h03;
  localparam logic [7:0] EpXferInterrupt  = 8'h03;
  localparam logic [7:0] EpNumberMask     = 8'h0F;
  localparam logic [7:0] EpMinLength      = 8'd7;
  localparam logic [7:0] PidIn            = 8'h69;
  localparam logic [10:0] MaxLenZeroPkt   = 11'h7FF;

  // Byte offsets inside a descriptor
  localparam logic [7:0] OffType     = 8'd1;
  localparam logic [7:0] OffAddress  = 8'd2;
  localparam logic [7:0] OffAttr     = 8'd3;
  localparam logic [7:0] OffSizeLow  = 8'd4;
  localparam logic [7:0] OffSizeHigh = 8'd5;
  localparam logic [7:0] OffInterval = 8'd6;

  // One result item
  typedef struct packed {
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet;
    logic [7:0]  interval_ms;
    logic [2:0]  schedule_slot;
    logic [31:0] transfer_token;
  } result_t;

  // Polling slot from the interval byte
  function automatic logic [2:0] slot_of(input logic [7:0] ms);
    logic [2:0] slot;
    if (ms >= 8'd32)      slot = 3'd5;
    else if (ms >= 8'd16) slot = 3'd4;
    else if (ms >= 8'd8)  slot = 3'd3;
    else if (ms >= 8'd4)  slot = 3'd2;
    else if (ms >= 8'd2)  slot = 3'd1;
    else                  slot = 3'd0;
    return slot;
  endfunction

  // IN token: pid, address, endpoint, toggle 0, max length
  function automatic logic [31:0] in_token(input logic [6:0]  addr,
                                           input logic [3:0]  ep,
                                           input logic [15:0] mp);
    logic [15:0] mp_m1;
    logic [10:0] maxlen;
    mp_m1  = mp - 16'd1;
    maxlen = (mp == 16'd0) ? MaxLenZeroPkt : mp_m1[10:0];
    return {maxlen, 1'b0, 1'b0, ep, addr, PidIn};
  endfunction

endpackage

>>> design/usb_interrupt_endpoint_finder.sv
// ----------------------------------------------------------------------------
// usb_interrupt_endpoint_finder
// Walks a configuration descriptor set and reports interrupt IN endpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one descriptor byte per request (data_byte_i, last_byte_i),
//   taken when in_valid_i is high and in_stall_o is low. last_byte_i marks
//   the final byte of a set; the walk state clears after it.
//   Output channel: one request per interrupt IN endpoint found, presented
//   on out_valid_o and taken when out_stall_i is low.
//   Configuration: cfg_we_i writes cfg_wdata_i into the device address used
//   in the transfer token; write only while the block is idle.
// Timing:
//   One byte per cycle sustained while in_stall_o is low. The result is
//   registered into the output's main or skid register as the endpoint's
//   interval byte is taken. Input stalls only while both registers hold
//   results, i.e. after the receiver has stalled with two results pending.
// Reset:
//   Clears the walk, empties the output registers, device address to zero.
// ----------------------------------------------------------------------------
module usb_interrupt_endpoint_finder
  import usbief_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  endpoint_number_o,
  output logic [15:0] max_packet_o,
  output logic [7:0]  interval_ms_o,
  output logic [2:0]  schedule_slot_o,
  output logic [31:0] transfer_token_o
);

  logic [6:0] dev_addr_q;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] addr_byte_q, addr_byte_d;
  logic [7:0] attr_q, attr_d;
  logic [7:0] size_lo_q, size_lo_d;
  logic [7:0] size_hi_q, size_hi_d;
  logic       stopped_q, stopped_d;

  logic       in_acc;
  logic       emit;
  logic [8:0] pos_inc;
  result_t    res;

  logic       main_v_q, main_v_d;
  logic       skid_v_q, skid_v_d;
  result_t    main_q, skid_q;
  logic       pop;
  logic       push;
  logic       load_main, load_skid, main_from_skid;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pos_inc = {1'b0, pos_q} + 9'd1;

  // Device address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Descriptor walk: next state and endpoint match
  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    type_d      = type_q;
    addr_byte_d = addr_byte_q;
    attr_d      = attr_q;
    size_lo_d   = size_lo_q;
    size_hi_d   = size_hi_q;
    stopped_d   = stopped_q;
    emit        = 1'b0;
    if (!stopped_q) begin
      if (pos_q == '0) begin
        len_d = data_byte_i;
        if (data_byte_i == 8'd0) begin
          stopped_d = 1'b1;
        end else if (data_byte_i >= 8'd2) begin
          pos_d = 8'd1;
        end
      end else begin
        if (pos_q == OffType)     type_d      = data_byte_i;
        if (pos_q == OffAddress)  addr_byte_d = data_byte_i;
        if (pos_q == OffAttr)     attr_d      = data_byte_i;
        if (pos_q == OffSizeLow)  size_lo_d   = data_byte_i;
        if (pos_q == OffSizeHigh) size_hi_d   = data_byte_i;
        emit = (pos_q == OffInterval) && (type_q == DescTypeEndpoint) &&
               (len_q >= EpMinLength) && ((addr_byte_q & EpDirInMask) != '0) &&
               ((attr_q & EpXferTypeMask) == EpXferInterrupt);
        pos_d = (pos_inc >= {1'b0, len_q}) ? 8'd0 : pos_inc[7:0];
      end
    end
    // end of set clears the walk
    if (last_byte_i) begin
      pos_d       = '0;
      len_d       = '0;
      type_d      = '0;
      addr_byte_d = '0;
      attr_d      = '0;
      size_lo_d   = '0;
      size_hi_d   = '0;
      stopped_d   = 1'b0;
    end
  end

  // Result fields
  always_comb begin
    logic [7:0] ep_byte;
    ep_byte             = addr_byte_q & EpNumberMask;
    res.endpoint_number = ep_byte[3:0];
    res.max_packet      = {size_hi_q, size_lo_q};
    res.interval_ms     = data_byte_i;
    res.schedule_slot   = slot_of(data_byte_i);
    res.transfer_token  = in_token(dev_addr_q, ep_byte[3:0], {size_hi_q, size_lo_q});
  end

  // Walk state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      type_q      <= '0;
      addr_byte_q <= '0;
      attr_q      <= '0;
      size_lo_q   <= '0;
      size_hi_q   <= '0;
      stopped_q   <= 1'b0;
    end else if (in_acc) begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      type_q      <= type_d;
      addr_byte_q <= addr_byte_d;
      attr_q      <= attr_d;
      size_lo_q   <= size_lo_d;
      size_hi_q   <= size_hi_d;
      stopped_q   <= stopped_d;
    end
  end

  // Output main + skid register control
  assign push       = in_acc && emit;
  assign pop        = main_v_q && !out_stall_i;
  assign in_stall_o = skid_v_q;

  always_comb begin
    main_v_d       = main_v_q;
    skid_v_d       = skid_v_q;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    main_from_skid = 1'b0;
    if (pop || !main_v_q) begin
      if (skid_v_q) begin
        main_from_skid = 1'b1;
        main_v_d       = 1'b1;
        skid_v_d       = push;
        load_skid      = push;
      end else begin
        main_v_d  = push;
        load_main = push;
      end
    end else if (push) begin
      skid_v_d  = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Output payload registers
  always_ff @(posedge clk_i) begin
    if (main_from_skid) begin
      main_q <= skid_q;
    end else if (load_main) begin
      main_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = main_v_q;
  assign endpoint_number_o = main_q.endpoint_number;
  assign max_packet_o      = main_q.max_packet;
  assign interval_ms_o     = main_q.interval_ms;
  assign schedule_slot_o   = main_q.schedule_slot;
  assign transfer_token_o  = main_q.transfer_token;

`ifndef SYNTHESIS
  // skid holds a result only behind a full main register
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid register valid while main register empty");

  // a stopped walk always sits at the length byte
  a_stopped_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (pos_q == '0))
    else $error("walk stopped away from offset zero");

  // last byte of a set clears the walk
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> (pos_q == '0 && !stopped_q && len_q == '0))
    else $error("walk not cleared after last byte");

  // a result is only emitted at the interval byte of an endpoint
  a_emit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (pos_q == OffInterval && type_q == DescTypeEndpoint))
    else $error("result emitted outside an endpoint interval byte");
`endif

endmodule
